@@ rtl/gf3_pkg.sv @@
// shared constants and types for the gravity force pipeline
package gf3_pkg;

	localparam int POS_FRAC_BITS = 16;
	localparam int FORCE_SHIFT = 2 * POS_FRAC_BITS - 16;

	localparam int POS_W = 32;
	localparam int MASS_W = 32;
	localparam int GC_W = 32;
	localparam int GS_W = 6;
	localparam int FORCE_W = 48;
	localparam int CFG_W = 32;

	localparam int MAG_W = POS_W + 1;
	localparam int SQ_W = 2 * MAG_W;
	localparam int S_W = SQ_W;
	localparam int ROOT_W = 34;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 2;
	localparam int GM_W = GC_W + MASS_W;
	localparam int K_W = GC_W + 2 * MASS_W;
	localparam int KP_W = 32 + MAG_W;
	localparam int DEN_W = 100;
	localparam int PROD_W = K_W + 32;
	localparam int NUM_W = PROD_W + FORCE_SHIFT;
	localparam int Q_W = FORCE_W;
	localparam int HI_W = NUM_W - Q_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	localparam int IN_TDATA_W = 6 * POS_W + 2 * MASS_W;
	localparam int OUT_TDATA_W = ((3 * FORCE_W + 2 + 7) / 8) * 8;

	localparam logic [FORCE_W-1:0] OUT_MAX = {1'b0, {(FORCE_W - 1){1'b1}}};
	localparam logic [FORCE_W-1:0] OUT_MINMAG = {1'b1, {(FORCE_W - 1){1'b0}}};

	typedef enum logic {
		REG_GRAV_CONST = 1'b0,
		REG_GRAV_SHIFT = 1'b1
	} reg_idx_t;

	// sideband that rides along the square root pipeline
	typedef struct packed {
		logic coinc;
		logic [2:0] neg;
		logic [2:0][MAG_W-1:0] mag;
		logic [K_W-1:0] k;
	} fside_t;

	// sideband that rides along the divider
	typedef struct packed {
		logic coinc;
		logic [2:0] neg;
	} dside_t;

endpackage

@@ rtl/gf3_front.sv @@
// front stages: position differences, squares, mass product and shift
module gf3_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [2:0][gf3_pkg::POS_W-1:0] src,
	input  logic [2:0][gf3_pkg::POS_W-1:0] tgt,
	input  logic [gf3_pkg::MASS_W-1:0]    src_mass,
	input  logic [gf3_pkg::MASS_W-1:0]    tgt_mass,
	input  logic [gf3_pkg::GC_W-1:0]      grav_const,
	input  logic [gf3_pkg::GS_W-1:0]      grav_shift,
	output logic                          out_valid,
	output logic [gf3_pkg::S_W-1:0]       sum_sq,
	output gf3_pkg::fside_t               side
);
	import gf3_pkg::*;

	logic [2:0][MAG_W-1:0] diff, mag;
	logic [2:0]            neg;

	logic                  v_s1, v_s2, v_s3, v_s4;
	logic [2:0]            neg_s1, neg_s2, neg_s3;
	logic [2:0][MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	logic [GM_W-1:0]       gm_s1;
	logic [MASS_W-1:0]     tm_s1;
	logic [2:0][SQ_W-1:0]  sq_s2;
	logic [GM_W-1:0]       pl_s2, ph_s2;
	logic [S_W-1:0]        sum_s3, sum_s4;
	logic [K_W-1:0]        kf_s3;
	fside_t                side_s4;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			diff[a] = {src[a][POS_W-1], src[a]} - {tgt[a][POS_W-1], tgt[a]};
			neg[a] = diff[a][MAG_W-1];
			mag[a] = neg[a] ? (~diff[a] + MAG_W'(1)) : diff[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= neg;
			mag_s1 <= mag;
			gm_s1 <= GM_W'(grav_const) * GM_W'(src_mass);
			tm_s1 <= tgt_mass;

			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			for (int a = 0; a < 3; a++) begin
				sq_s2[a] <= SQ_W'(mag_s1[a]) * SQ_W'(mag_s1[a]);
			end
			pl_s2 <= GM_W'(gm_s1[31:0]) * GM_W'(tm_s1);
			ph_s2 <= GM_W'(gm_s1[GM_W-1:32]) * GM_W'(tm_s1);

			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			kf_s3 <= {ph_s2, 32'b0} + K_W'(pl_s2);

			sum_s4 <= sum_s3;
			side_s4.coinc <= (sum_s3 == '0);
			side_s4.neg <= neg_s3;
			side_s4.mag <= mag_s3;
			side_s4.k <= kf_s3 >> grav_shift;
		end
	end

	assign out_valid = v_s4;
	assign sum_sq = sum_s4;
	assign side = side_s4;

endmodule

@@ rtl/gf3_isqrt.sv @@
// pipelined integer square root, one root bit per stage
module gf3_isqrt (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic [gf3_pkg::S_W-1:0] sum_sq,
	input  gf3_pkg::fside_t         in_side,
	output logic                    out_valid,
	output logic [gf3_pkg::S_W-1:0] out_sum,
	output logic [gf3_pkg::ROOT_W-1:0] root,
	output gf3_pkg::fside_t         out_side
);
	import gf3_pkg::*;

	logic              v_s   [ROOT_W];
	logic [S_W-1:0]    sum_s [ROOT_W];
	logic [REM_W-1:0]  rem_s [ROOT_W];
	logic [ROOT_W-1:0] res_s [ROOT_W];
	fside_t            side_s [ROOT_W];

	for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
		logic              v_in;
		logic [S_W-1:0]    sum_in;
		fside_t            side_in;
		logic [REM_W-1:0]  rem_in, rem_sh, trial;
		logic [ROOT_W-1:0] res_in;
		logic [RAD_W-1:0]  rad;
		logic              ge;

		if (i == 0) begin : g_first
			assign v_in = in_valid;
			assign sum_in = sum_sq;
			assign side_in = in_side;
			assign rem_in = '0;
			assign res_in = '0;
		end else begin : g_next
			assign v_in = v_s[i-1];
			assign sum_in = sum_s[i-1];
			assign side_in = side_s[i-1];
			assign rem_in = rem_s[i-1];
			assign res_in = res_s[i-1];
		end

		// bring down the next pair of radicand bits
		assign rad = RAD_W'(sum_in);
		assign rem_sh = {rem_in[REM_W-3:0], rad[2*(ROOT_W-1-i) +: 2]};
		assign trial = {res_in, 2'b01};
		assign ge = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sum_s[i] <= sum_in;
				side_s[i] <= side_in;
				rem_s[i] <= ge ? (rem_sh - trial) : rem_sh;
				res_s[i] <= {res_in[ROOT_W-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[ROOT_W-1];
	assign out_sum = sum_s[ROOT_W-1];
	assign root = res_s[ROOT_W-1];
	assign out_side = side_s[ROOT_W-1];

endmodule

@@ rtl/gf3_mul.sv @@
// denominator s*r and numerator k*|d| shifted by FORCE_SHIFT, from 32-bit partial products
module gf3_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  logic                       in_valid,
	input  logic [gf3_pkg::S_W-1:0]    sum_sq,
	input  logic [gf3_pkg::ROOT_W-1:0] root,
	input  gf3_pkg::fside_t            in_side,
	output logic                       out_valid,
	output logic [gf3_pkg::DEN_W-1:0]  den,
	output logic [2:0][gf3_pkg::NUM_W-1:0] num,
	output gf3_pkg::dside_t            out_side
);
	import gf3_pkg::*;

	localparam int PDL_W = 32 + ROOT_W;
	localparam int PDH_W = (S_W - 32) + ROOT_W;

	logic                       v_s1, v_s2;
	logic [PDL_W-1:0]           pdl_s1;
	logic [PDH_W-1:0]           pdh_s1;
	logic [2:0][2:0][KP_W-1:0]  pk_s1;
	dside_t                     side_s1, side_s2;
	logic [DEN_W-1:0]           den_s2;
	logic [2:0][NUM_W-1:0]      num_s2;
	logic [2:0][PROD_W-1:0]     prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			prod[a] = (PROD_W'(pk_s1[a][2]) << 64) + (PROD_W'(pk_s1[a][1]) << 32)
				+ PROD_W'(pk_s1[a][0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pdl_s1 <= PDL_W'(sum_sq[31:0]) * PDL_W'(root);
			pdh_s1 <= PDH_W'(sum_sq[S_W-1:32]) * PDH_W'(root);
			for (int a = 0; a < 3; a++) begin
				for (int j = 0; j < 3; j++) begin
					pk_s1[a][j] <= KP_W'(in_side.k[32*j +: 32]) * KP_W'(in_side.mag[a]);
				end
			end
			side_s1.coinc <= in_side.coinc;
			side_s1.neg <= in_side.neg;

			den_s2 <= (DEN_W'(pdh_s1) << 32) + DEN_W'(pdl_s1);
			for (int a = 0; a < 3; a++) begin
				num_s2[a] <= NUM_W'(prod[a]) << FORCE_SHIFT;
			end
			side_s2 <= side_s1;
		end
	end

	assign out_valid = v_s2;
	assign den = den_s2;
	assign num = num_s2;
	assign out_side = side_s2;

endmodule

@@ rtl/gf3_div.sv @@
// pipelined restoring divider for three axes, one quotient bit per stage
module gf3_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [gf3_pkg::DEN_W-1:0]     den,
	input  logic [2:0][gf3_pkg::NUM_W-1:0] num,
	input  gf3_pkg::dside_t               in_side,
	output logic                          out_valid,
	output logic [2:0][gf3_pkg::Q_W-1:0]  quo,
	output logic [2:0]                    big,
	output gf3_pkg::dside_t               out_side
);
	import gf3_pkg::*;

	localparam int N_ST = Q_W + 1;

	logic                        v_s    [N_ST];
	logic [DEN_W-1:0]            den_s  [N_ST];
	logic [2:0][DEN_W-1:0]       rem_s  [N_ST];
	logic [2:0][Q_W-1:0]         lq_s   [N_ST];
	logic [2:0]                  big_s  [N_ST];
	dside_t                      side_s [N_ST];

	// setup stage: quotient would not fit in Q_W bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den;
			side_s[0] <= in_side;
			for (int a = 0; a < 3; a++) begin
				big_s[0][a] <= (CMP_W'(num[a][NUM_W-1:Q_W]) >= CMP_W'(den));
				rem_s[0][a] <= DEN_W'(num[a][NUM_W-1:Q_W]);
				lq_s[0][a] <= num[a][Q_W-1:0];
			end
		end
	end

	for (genvar i = 1; i < N_ST; i++) begin : g_step
		logic [2:0][DEN_W:0] t;
		logic [2:0][DEN_W:0] diff;
		logic [2:0]          ge;

		always_comb begin
			for (int a = 0; a < 3; a++) begin
				t[a] = {rem_s[i-1][a], lq_s[i-1][a][Q_W-1]};
				diff[a] = t[a] - {1'b0, den_s[i-1]};
				ge[a] = (t[a] >= {1'b0, den_s[i-1]});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= v_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[i] <= den_s[i-1];
				side_s[i] <= side_s[i-1];
				big_s[i] <= big_s[i-1];
				for (int a = 0; a < 3; a++) begin
					rem_s[i][a] <= ge[a] ? diff[a][DEN_W-1:0] : t[a][DEN_W-1:0];
					lq_s[i][a] <= {lq_s[i-1][a][Q_W-2:0], ge[a]};
				end
			end
		end
	end

	assign out_valid = v_s[N_ST-1];
	assign quo = lq_s[N_ST-1];
	assign big = big_s[N_ST-1];
	assign out_side = side_s[N_ST-1];

endmodule

@@ rtl/gravity_force_3d_top.sv @@
// gravity force top level: config registers, pipeline and output register
//
//  channel   | direction | handshake        | payload
//  s_        | in        | tvalid / tready  | two positions and two masses
//  m_        | out       | tvalid / tready  | force vector and two flags
//  cfg_      | in        | we               | grav_const, grav_shift
//
// one item per cycle while the output is not stalled; the pipeline is four front stages, 34 square root
// stages (one root bit each), two multiply stages, 49 divider stages (setup
// and one quotient bit each) and the output register
// reset clears all valid bits and loads grav_const = 1, grav_shift = 0
// the whole pipeline holds while the output register is full and not taken
module gravity_force_3d_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// source_x, source_y, source_z, target_x, target_y, target_z,
	// source_mass, target_mass
	input  logic [gf3_pkg::IN_TDATA_W-1:0]       s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// force_x, force_y, force_z, coincident, saturated, zero pad
	output logic [gf3_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  logic                                 cfg_we,
	input  logic                                 cfg_index,
	input  logic [gf3_pkg::CFG_W-1:0]            cfg_wdata
);
	import gf3_pkg::*;

	localparam int OUT_PAD = OUT_TDATA_W - 3 * FORCE_W - 2;

	logic [GC_W-1:0]         gc_q;
	logic [GS_W-1:0]         gs_q;
	logic                    en;

	logic [2:0][POS_W-1:0]   src, tgt;
	logic [MASS_W-1:0]       src_mass, tgt_mass;

	logic                    fr_valid;
	logic [S_W-1:0]          fr_sum;
	fside_t                  fr_side;
	logic                    sq_valid;
	logic [S_W-1:0]          sq_sum;
	logic [ROOT_W-1:0]       sq_root;
	fside_t                  sq_side;
	logic                    mu_valid;
	logic [DEN_W-1:0]        mu_den;
	logic [2:0][NUM_W-1:0]   mu_num;
	dside_t                  mu_side;
	logic                    dv_valid;
	logic [2:0][Q_W-1:0]     dv_quo;
	logic [2:0]              dv_big;
	dside_t                  dv_side;

	logic [2:0][FORCE_W-1:0] force_d;
	logic [2:0]              sat_ax;
	logic [FORCE_W-1:0]      lim, qq;

	logic                    out_valid_q;
	logic [2:0][FORCE_W-1:0] force_q;
	logic                    coinc_q, sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gc_q <= GC_W'(1);
			gs_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_GRAV_CONST: gc_q <= cfg_wdata[GC_W-1:0];
				REG_GRAV_SHIFT: gs_q <= cfg_wdata[GS_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !out_valid_q || m_tready;
	assign s_tready = en;

	assign src = s_tdata[3*POS_W-1:0];
	assign tgt = s_tdata[6*POS_W-1:3*POS_W];
	assign src_mass = s_tdata[6*POS_W +: MASS_W];
	assign tgt_mass = s_tdata[6*POS_W+MASS_W +: MASS_W];

	gf3_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.src        (src),
		.tgt        (tgt),
		.src_mass   (src_mass),
		.tgt_mass   (tgt_mass),
		.grav_const (gc_q),
		.grav_shift (gs_q),
		.out_valid  (fr_valid),
		.sum_sq     (fr_sum),
		.side       (fr_side)
	);

	gf3_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.sum_sq    (fr_sum),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.out_sum   (sq_sum),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	gf3_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.sum_sq    (sq_sum),
		.root      (sq_root),
		.in_side   (sq_side),
		.out_valid (mu_valid),
		.den       (mu_den),
		.num       (mu_num),
		.out_side  (mu_side)
	);

	gf3_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (mu_valid),
		.den       (mu_den),
		.num       (mu_num),
		.in_side   (mu_side),
		.out_valid (dv_valid),
		.quo       (dv_quo),
		.big       (dv_big),
		.out_side  (dv_side)
	);

	// clamp to the signed range, then apply the sign of the difference
	always_comb begin
		lim = '0;
		qq = '0;
		for (int a = 0; a < 3; a++) begin
			lim = dv_side.neg[a] ? OUT_MINMAG : OUT_MAX;
			sat_ax[a] = dv_big[a] || (dv_quo[a] > lim);
			qq = sat_ax[a] ? lim : dv_quo[a];
			force_d[a] = dv_side.neg[a] ? (~qq + FORCE_W'(1)) : qq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coinc_q <= dv_side.coinc;
			sat_q <= !dv_side.coinc && (sat_ax != '0);
			force_q <= dv_side.coinc ? '0 : force_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {{OUT_PAD{1'b0}}, sat_q, coinc_q, force_q};

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("input taken while output stalled");

	a_coinc_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && coinc_q) |-> !sat_q)
		else $error("coincident result flagged saturated");

	a_coinc_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && coinc_q) |-> (force_q == '0))
		else $error("coincident result has nonzero force");

	a_valid_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(en && dv_valid) |=> m_tvalid)
		else $error("divider result lost at output register");

endmodule

@@ tb/gravity_force_3d_top_tb.sv @@
// testbench for gravity_force_3d_top: exact force prediction, random stalls, register phases
module gravity_force_3d_top_tb;
	import gf3_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int DRAIN_CYCLES = 120;

	typedef logic [255:0] wide_t;

	typedef struct packed {
		logic [FORCE_W-1:0] fx;
		logic [FORCE_W-1:0] fy;
		logic [FORCE_W-1:0] fz;
		logic coinc;
		logic sat;
	} force_res_t;

	class force_scoreboard;
		force_res_t pending[$];
		logic [GC_W-1:0] grav_const = 1;
		logic [GS_W-1:0] grav_shift = 0;
		int errors = 0;

		function force_res_t predict(logic [IN_TDATA_W-1:0] din);
			force_res_t r;
			logic signed [POS_W:0] d;
			logic [2:0] neg;
			wide_t mag[3];
			wide_t s, root, cand, k, num, den, q, lim;
			logic [FORCE_W-1:0] comp[3];
			s = '0;
			r = '0;
			for (int a = 0; a < 3; a++) begin
				d = $signed({din[a*32+31], din[a*32 +: 32]})
					- $signed({din[(a+3)*32+31], din[(a+3)*32 +: 32]});
				neg[a] = d[POS_W];
				mag[a] = neg[a] ? wide_t'(-d) & 256'h1_FFFF_FFFF : wide_t'(d);
				s = s + mag[a] * mag[a];
			end
			if (s == 0) begin
				r.coinc = 1'b1;
				return r;
			end
			root = '0;
			for (int b = 33; b >= 0; b--) begin
				cand = root | (wide_t'(1) << b);
				if (cand * cand <= s)
					root = cand;
			end
			den = s * root;
			k = (wide_t'(grav_const) * wide_t'(din[192 +: 32]) * wide_t'(din[224 +: 32]))
				>> grav_shift;
			for (int a = 0; a < 3; a++) begin
				num = (k * mag[a]) << FORCE_SHIFT;
				q = num / den;
				lim = neg[a] ? wide_t'(OUT_MINMAG) : wide_t'(OUT_MAX);
				if (q > lim) begin
					q = lim;
					r.sat = 1'b1;
				end
				comp[a] = neg[a] ? FORCE_W'(-q) : FORCE_W'(q);
			end
			r.fx = comp[0];
			r.fy = comp[1];
			r.fz = comp[2];
			return r;
		endfunction

		function void note_item(logic [IN_TDATA_W-1:0] din);
			pending.push_back(predict(din));
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] dout);
			force_res_t exp_r, got;
			got.fx = dout[0 +: FORCE_W];
			got.fy = dout[FORCE_W +: FORCE_W];
			got.fz = dout[2*FORCE_W +: FORCE_W];
			got.coinc = dout[3*FORCE_W];
			got.sat = dout[3*FORCE_W+1];
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result item %h", dout);
				return;
			end
			exp_r = pending.pop_front();
			if (got.fx !== exp_r.fx || got.fy !== exp_r.fy || got.fz !== exp_r.fz
				|| got.coinc !== exp_r.coinc || got.sat !== exp_r.sat) begin
				errors++;
				if (errors <= 10)
					$display("force mismatch: exp x=%h y=%h z=%h c=%b s=%b, got x=%h y=%h z=%h c=%b s=%b",
						exp_r.fx, exp_r.fy, exp_r.fz, exp_r.coinc, exp_r.sat,
						got.fx, got.fy, got.fz, got.coinc, got.sat);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	force_scoreboard sb = new();
	bit calm = 0;
	int cycles = 0;
	int stall_left = 0;

	gravity_force_3d_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_item(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	// receiver back-pressure in random bursts
	always @(posedge clk) begin
		if (!arst_n || calm) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 16) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	function automatic logic [IN_TDATA_W-1:0] pack_item(logic [31:0] sx, logic [31:0] sy,
		logic [31:0] sz, logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
		logic [31:0] sm, logic [31:0] tm);
		return {tm, sm, tz, ty, tx, sz, sy, sx};
	endfunction

	function automatic logic [IN_TDATA_W-1:0] random_item();
		logic [31:0] p[6];
		logic [31:0] sm, tm;
		int kind;
		kind = $urandom_range(0, 9);
		for (int i = 0; i < 6; i++)
			p[i] = $urandom();
		sm = $urandom() >> $urandom_range(0, 31);
		tm = $urandom() >> $urandom_range(0, 31);
		if (kind < 6) begin
			// nearby bodies, offsets of varied scale
			for (int i = 0; i < 3; i++)
				p[i+3] = p[i] + (($urandom() >> $urandom_range(0, 31))
					* ($urandom_range(0, 1) ? 1 : -1));
		end else if (kind == 6) begin
			for (int i = 0; i < 3; i++)
				p[i+3] = p[i];
		end else if (kind == 7) begin
			p[3] = p[0];
			p[4] = p[1] + $urandom_range(0, 3) - 1;
			p[5] = p[2];
		end
		return pack_item(p[0], p[1], p[2], p[3], p[4], p[5], sm, tm);
	endfunction

	task automatic send_item(logic [IN_TDATA_W-1:0] din);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 16);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= din;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GRAV_CONST)
			sb.grav_const = val;
		else
			sb.grav_shift = val[GS_W-1:0];
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic directed_items();
		logic [31:0] one = 32'h0001_0000;
		send_item(pack_item(0, 0, 0, 0, 0, 0, 0, 0));
		send_item(pack_item(32'h7FFF_FFFF, 5, 9, 32'h7FFF_FFFF, 5, 9, '1, '1));
		send_item(pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1));
		send_item(pack_item(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, '1, '1));
		send_item(pack_item(one, 0, 0, 0, 0, 0, one, one));
		send_item(pack_item(0, one, 0, 0, 0, 0, one, one));
		send_item(pack_item(0, 0, one, 0, 0, 0, one, one));
		send_item(pack_item(0, 0, 0, one, 0, 0, one, one));
		send_item(pack_item(0, 0, 0, 0, one, 0, one, one));
		send_item(pack_item(0, 0, 0, 0, 0, one, one, one));
		send_item(pack_item(1, 0, 0, 0, 0, 0, '1, '1));
		send_item(pack_item(0, 0, 0, 0, 0, 32'hFFFF_FFFF, '1, '1));
		send_item(pack_item(1, 1, 1, 0, 0, 0, '1, '1));
		send_item(pack_item(one, one, one, 0, 0, 0, 0, '1));
		send_item(pack_item(one, one, one, 0, 0, 0, '1, 0));
		send_item(pack_item(32'hFFFF_0000, 32'h0003_0000, 32'hFFFC_0000,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0050_0000, 32'h0002_8000));
		send_item(pack_item(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
			32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F, '1, '1));
		end_burst();
	endtask

	task automatic random_items(int n);
		for (int i = 0; i < n; i++)
			send_item(random_item());
		end_burst();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_GRAV_CONST;
		cfg_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values of the constant and shift
		directed_items();
		random_items(100);
		drain();

		write_reg(REG_GRAV_CONST, 32'hFFFF_FFFF);
		write_reg(REG_GRAV_SHIFT, 6'd63);
		directed_items();
		random_items(120);
		drain();

		write_reg(REG_GRAV_CONST, 32'd0);
		write_reg(REG_GRAV_SHIFT, 6'd0);
		random_items(40);
		drain();

		write_reg(REG_GRAV_CONST, 32'hFFFF_FFFF);
		random_items(100);
		drain();

		// realistic constant scaled down
		write_reg(REG_GRAV_CONST, 32'h8ED9_B6F4);
		write_reg(REG_GRAV_SHIFT, 6'd48);
		directed_items();
		random_items(150);
		drain();

		write_reg(REG_GRAV_CONST, $urandom());
		write_reg(REG_GRAV_SHIFT, $urandom_range(0, 63));
		random_items(120);

		// no idling in the last part
		calm = 1;
		random_items(100);
		drain();

		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
